// ----- src/mmc3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MMC3-style bank mapper package
// Shared types and constants for the bank mapper with scanline interrupt.
// ----------------------------------------------------------------------------
package mmc3_pkg;

   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned BANK_CNT_W  = 9;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 9;

   localparam logic [ADDR_W-1:0]     SOFT_RESET_ADDR = 16'h6000;
   localparam logic [BYTE_W-1:0]     PAIR_MASK       = 8'hFE;
   localparam int unsigned           CHR_SWAP_BIT    = 7;
   localparam int unsigned           PRG_SWAP_BIT    = 6;
   localparam logic [BANK_CNT_W-1:0] PRG_COUNT_RESET = 9'd32;

   typedef enum logic [1:0] {
      REQ_CPU_WRITE = 2'd0,
      REQ_TICK      = 2'd1,
      REQ_PRG_READ  = 2'd2,
      REQ_CHR_READ  = 2'd3
   } req_kind_type;

   // Decode of address bits 14:13 and 0 for writes in the upper half.
   typedef enum logic [2:0] {
      WR_MODE       = 3'b000,
      WR_BANK_DATA  = 3'b001,
      WR_MIRROR     = 3'b010,
      WR_UNUSED     = 3'b011,
      WR_IRQ_COUNT  = 3'b100,
      WR_IRQ_LATCH  = 3'b101,
      WR_IRQ_OFF    = 3'b110,
      WR_IRQ_ON     = 3'b111
   } write_reg_type;

   typedef enum logic [2:0] {
      SEL_CHR_PAIR_LOW  = 3'd0,
      SEL_CHR_PAIR_HIGH = 3'd1,
      SEL_CHR_SINGLE_0  = 3'd2,
      SEL_CHR_SINGLE_1  = 3'd3,
      SEL_CHR_SINGLE_2  = 3'd4,
      SEL_CHR_SINGLE_3  = 3'd5,
      SEL_PRG_FIRST     = 3'd6,
      SEL_PRG_SECOND    = 3'd7
   } bank_sel_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PRG_BANK_COUNT = 2'd0,
      CSR_FOUR_SCREEN    = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [ADDR_W-1:0] address;
      logic [BYTE_W-1:0] value;
      logic              in_vblank;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] bank_number;
      logic              irq_pulse;
      logic              mirror_horizontal;
   } rsp_payload_type;

endpackage

// ----- src/mmc3_style_bank_mapper_irq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MMC3-style bank mapper with scanline interrupt
// Decodes CPU writes into bank, mirroring and interrupt registers, answers
// program and character bank lookups and counts scanline ticks.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake         | Payload
//  req_    | in        | req_valid/stall   | req_payload_type
//  rsp_    | out       | rsp_valid/stall   | rsp_payload_type
//  csr_    | in        | csr_valid/ready   | csr_index, csr_wdata
//
// One transaction is taken per cycle while req_stall is low; its result is registered
// in the result register, which is backed by a one-entry skid buffer, so req_stall
// rises only when both hold a result that has not been taken.
// Reset is synchronous and restores every control and valid register; the result and skid data registers are not reset.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
module mmc3_style_bank_mapper_irq
   import mmc3_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [BANK_CNT_W-1:0] prg_bank_count_ff;
   logic                  four_screen_ff;

   logic [BYTE_W-1:0] bank_mode_ff, bank_mode_in;
   logic [BYTE_W-1:0] chr_pair_low_ff, chr_pair_low_in;
   logic [BYTE_W-1:0] chr_pair_high_ff, chr_pair_high_in;
   logic [BYTE_W-1:0] chr_single_ff [4];
   logic [BYTE_W-1:0] chr_single_in [4];
   logic [BYTE_W-1:0] prg_first_ff, prg_first_in;
   logic [BYTE_W-1:0] prg_second_ff, prg_second_in;
   logic [BYTE_W-1:0] irq_counter_ff, irq_counter_in;
   logic [BYTE_W-1:0] irq_reload_ff, irq_reload_in;
   logic              irq_enabled_ff, irq_enabled_in;
   logic              mirror_ff, mirror_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;
   logic              skid_valid_ff, skid_valid_in;
   rsp_payload_type   skid_data_ff, skid_data_in;

   logic              push;
   logic              pop;
   rsp_payload_type   result;
   req_kind_type      kind;
   write_reg_type     wr_reg;
   logic [1:0]        prg_slot;
   logic [2:0]        chr_slot;
   logic [BYTE_W-1:0] prg_last;
   logic [BYTE_W-1:0] prg_second_last;

   assign push      = req_valid && !req_stall;
   assign pop       = rsp_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign csr_ready = 1'b1;

   assign kind     = req_kind_type'(req_payload.req_type);
   assign wr_reg   = write_reg_type'({req_payload.address[14:13], req_payload.address[0]});
   assign prg_slot = req_payload.address[14:13];
   assign chr_slot = req_payload.address[12:10] ^ {bank_mode_ff[CHR_SWAP_BIT], 2'b00};
   assign prg_last        = prg_bank_count_ff[BYTE_W-1:0] - 8'd1;
   assign prg_second_last = prg_bank_count_ff[BYTE_W-1:0] - 8'd2;

   always_comb begin
      bank_mode_in     = bank_mode_ff;
      chr_pair_low_in  = chr_pair_low_ff;
      chr_pair_high_in = chr_pair_high_ff;
      chr_single_in    = chr_single_ff;
      prg_first_in     = prg_first_ff;
      prg_second_in    = prg_second_ff;
      irq_counter_in   = irq_counter_ff;
      irq_reload_in    = irq_reload_ff;
      irq_enabled_in   = irq_enabled_ff;
      mirror_in        = mirror_ff;
      result           = '0;

      case (kind)
         REQ_CPU_WRITE: begin
            if (!req_payload.address[ADDR_W-1]) begin
               if (req_payload.address == SOFT_RESET_ADDR && req_payload.value == '0) begin
                  bank_mode_in     = '0;
                  chr_pair_low_in  = 8'd0;
                  chr_pair_high_in = 8'd2;
                  chr_single_in    = '{8'd4, 8'd5, 8'd6, 8'd7};
                  prg_first_in     = 8'd0;
                  prg_second_in    = 8'd1;
                  irq_counter_in   = '0;
                  irq_reload_in    = '0;
                  irq_enabled_in   = 1'b0;
               end
            end else begin
               case (wr_reg)
                  WR_MODE: bank_mode_in = req_payload.value;
                  WR_BANK_DATA: begin
                     case (bank_sel_type'(bank_mode_ff[2:0]))
                        SEL_CHR_PAIR_LOW:  chr_pair_low_in  = req_payload.value & PAIR_MASK;
                        SEL_CHR_PAIR_HIGH: chr_pair_high_in = req_payload.value & PAIR_MASK;
                        SEL_CHR_SINGLE_0:  chr_single_in[0] = req_payload.value;
                        SEL_CHR_SINGLE_1:  chr_single_in[1] = req_payload.value;
                        SEL_CHR_SINGLE_2:  chr_single_in[2] = req_payload.value;
                        SEL_CHR_SINGLE_3:  chr_single_in[3] = req_payload.value;
                        SEL_PRG_FIRST:     prg_first_in     = req_payload.value;
                        default:           prg_second_in    = req_payload.value;
                     endcase
                  end
                  WR_MIRROR: begin
                     if (!four_screen_ff) begin
                        mirror_in = req_payload.value[0];
                     end
                  end
                  WR_IRQ_COUNT: irq_counter_in = req_payload.value;
                  WR_IRQ_LATCH: irq_reload_in  = req_payload.value;
                  WR_IRQ_OFF:   irq_enabled_in = 1'b0;
                  WR_IRQ_ON:    irq_enabled_in = 1'b1;
                  default: ;
               endcase
            end
         end
         REQ_TICK: begin
            if (!req_payload.in_vblank && irq_enabled_ff) begin
               if (irq_counter_ff == '0) begin
                  irq_counter_in   = irq_reload_ff;
                  result.irq_pulse = 1'b1;
               end else begin
                  irq_counter_in = irq_counter_ff - 8'd1;
               end
            end
         end
         REQ_PRG_READ: begin
            case (prg_slot)
               2'd0: result.bank_number = bank_mode_ff[PRG_SWAP_BIT] ? prg_second_last
                                                                    : prg_first_ff;
               2'd1: result.bank_number = prg_second_ff;
               2'd2: result.bank_number = bank_mode_ff[PRG_SWAP_BIT] ? prg_first_ff
                                                                    : prg_second_last;
               default: result.bank_number = prg_last;
            endcase
         end
         default: begin
            case (chr_slot)
               3'd0: result.bank_number = chr_pair_low_ff;
               3'd1: result.bank_number = chr_pair_low_ff + 8'd1;
               3'd2: result.bank_number = chr_pair_high_ff;
               3'd3: result.bank_number = chr_pair_high_ff + 8'd1;
               default: result.bank_number = chr_single_ff[chr_slot[1:0]];
            endcase
         end
      endcase

      result.mirror_horizontal = mirror_in;
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = push;
            rsp_data_in  = result;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_bank_count_ff <= PRG_COUNT_RESET;
         four_screen_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_PRG_BANK_COUNT: prg_bank_count_ff <= csr_wdata;
            CSR_FOUR_SCREEN:    four_screen_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_mode_ff     <= '0;
         chr_pair_low_ff  <= 8'd0;
         chr_pair_high_ff <= 8'd2;
         chr_single_ff    <= '{8'd4, 8'd5, 8'd6, 8'd7};
         prg_first_ff     <= 8'd0;
         prg_second_ff    <= 8'd1;
         irq_counter_ff   <= '0;
         irq_reload_ff    <= '0;
         irq_enabled_ff   <= 1'b0;
         mirror_ff        <= 1'b0;
      end else if (push) begin
         bank_mode_ff     <= bank_mode_in;
         chr_pair_low_ff  <= chr_pair_low_in;
         chr_pair_high_ff <= chr_pair_high_in;
         chr_single_ff    <= chr_single_in;
         prg_first_ff     <= prg_first_in;
         prg_second_ff    <= prg_second_in;
         irq_counter_ff   <= irq_counter_in;
         irq_reload_ff    <= irq_reload_in;
         irq_enabled_ff   <= irq_enabled_in;
         mirror_ff        <= mirror_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   // The skid buffer is only ever filled behind a full result register.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid buffer holds a result while the output register is empty");

   // A transaction taken while the output waits must land in the skid buffer.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && push) |=> skid_valid_ff)
      else $error("transaction lost behind a stalled result");

   // An interrupt pulse reloads the counter from the latch.
   assert property (@(posedge clock) disable iff (reset)
      (push && result.irq_pulse) |=> (irq_counter_ff == $past(irq_reload_ff)))
      else $error("counter not reloaded on interrupt pulse");

endmodule
